FILE: rtl/core/fkc_pkg.sv
package fkc_pkg;

   localparam int unsigned CODE_W  = 3;
   localparam int unsigned CNT_W   = 9;
   localparam int unsigned LONG_W  = 16;
   localparam int unsigned TALLY_W = 8;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [7:0]  DEBOUNCE_RESET   = 8'd10;
   localparam logic [7:0]  LONG_HOLD_RESET  = 8'd250;
   localparam logic [15:0] REPEAT_RESET     = 16'd500;
   localparam logic [15:0] DOUBLE_GAP_RESET = 16'd200;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE   = 2'd0,
      CSR_LONG_HOLD  = 2'd1,
      CSR_REPEAT     = 2'd2,
      CSR_DOUBLE_GAP = 2'd3
   } csr_index_type;

   typedef enum logic [CODE_W-1:0] {
      EV_NONE        = 3'd0,
      EV_KEY1        = 3'd1,
      EV_KEY2_SINGLE = 3'd2,
      EV_KEY2_DOUBLE = 3'd3,
      EV_KEY2_LONG   = 3'd4,
      EV_KEY3_SINGLE = 3'd5,
      EV_KEY3_DOUBLE = 3'd6,
      EV_KEY4        = 3'd7
   } event_code_type;

   typedef struct packed {
      logic [7:0]  debounce_ticks;
      logic [7:0]  long_hold_ticks;
      logic [15:0] repeat_ticks;
      logic [15:0] double_gap_ticks;
   } cfg_type;

   typedef struct packed {
      logic single_click;
      logic double_click;
      logic long_press;
   } click_event_type;

endpackage

FILE: rtl/core/four_key_click_classifier.sv
// Four-key scan classifier. Each req_ transaction is one scan tick with four
// active-low key levels and yields exactly one rsp_ transaction carrying an
// event code (0 when nothing happened). Keys one and four report one event per
// debounced press; keys two and three report single, double and repeating long
// presses, with key three's long press using its single code. When several keys
// fire in the same tick the highest-numbered key wins. A tick is accepted every
// clock cycle while req_stall is low: the key state is registered and the
// result lands in a two-entry output queue, so req_stall rises only when two
// results are waiting. Timing registers are written through the csr_ port
// (always ready) and should only change while no ticks are in flight.
module four_key_click_classifier (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_key_one_level,
   input  logic                                req_key_two_level,
   input  logic                                req_key_three_level,
   input  logic                                req_key_four_level,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [fkc_pkg::CODE_W-1:0]          rsp_event_code,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fkc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fkc_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import fkc_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   logic            accept;
   logic            queue_full;
   logic            key1_fire, key4_fire;
   click_event_type key2_ev, key3_ev;
   event_code_type  code;

   assign csr_ready = 1'b1;
   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEBOUNCE:   cfg_in.debounce_ticks   = csr_wdata[7:0];
            CSR_LONG_HOLD:  cfg_in.long_hold_ticks  = csr_wdata[7:0];
            CSR_REPEAT:     cfg_in.repeat_ticks     = csr_wdata;
            CSR_DOUBLE_GAP: cfg_in.double_gap_ticks = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks   <= DEBOUNCE_RESET;
         cfg_ff.long_hold_ticks  <= LONG_HOLD_RESET;
         cfg_ff.repeat_ticks     <= REPEAT_RESET;
         cfg_ff.double_gap_ticks <= DOUBLE_GAP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fkc_simple_key u_key_one (
      .clock          (clock),
      .reset          (reset),
      .enable         (accept),
      .level          (req_key_one_level),
      .debounce_ticks (cfg_ff.debounce_ticks),
      .fire           (key1_fire)
   );

   fkc_click_key u_key_two (
      .clock  (clock),
      .reset  (reset),
      .enable (accept),
      .level  (req_key_two_level),
      .cfg    (cfg_ff),
      .events (key2_ev)
   );

   fkc_click_key u_key_three (
      .clock  (clock),
      .reset  (reset),
      .enable (accept),
      .level  (req_key_three_level),
      .cfg    (cfg_ff),
      .events (key3_ev)
   );

   fkc_simple_key u_key_four (
      .clock          (clock),
      .reset          (reset),
      .enable         (accept),
      .level          (req_key_four_level),
      .debounce_ticks (cfg_ff.debounce_ticks),
      .fire           (key4_fire)
   );

   // highest key wins
   always_comb begin
      priority if (key4_fire)              code = EV_KEY4;
      else if (key3_ev.double_click)       code = EV_KEY3_DOUBLE;
      else if (key3_ev.single_click || key3_ev.long_press)
                                           code = EV_KEY3_SINGLE;
      else if (key2_ev.double_click)       code = EV_KEY2_DOUBLE;
      else if (key2_ev.long_press)         code = EV_KEY2_LONG;
      else if (key2_ev.single_click)       code = EV_KEY2_SINGLE;
      else if (key1_fire)                  code = EV_KEY1;
      else                                 code = EV_NONE;
   end

   fkc_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_code (code),
      .full      (queue_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_code  (rsp_event_code)
   );

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted transaction left no result");

   a_key4_wins: assert property (@(posedge clock) disable iff (reset)
      key4_fire |-> code == EV_KEY4)
      else $error("key four event lost to a lower key");

   a_cfg_reset: assert property (@(posedge clock)
      $past(reset) |-> cfg_ff.debounce_ticks == DEBOUNCE_RESET
                    && cfg_ff.repeat_ticks == REPEAT_RESET)
      else $error("timing registers not at reset values");

endmodule

FILE: rtl/core/fkc_simple_key.sv
module fkc_simple_key (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             level,
   input  logic [7:0]       debounce_ticks,
   output logic             fire
);
   import fkc_pkg::*;

   logic             lock_ff, lock_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] count_sum;

   always_comb begin
      lock_in   = lock_ff;
      count_in  = count_ff;
      fire      = 1'b0;
      count_sum = count_ff + CNT_W'(1);
      if (level) begin
         lock_in  = 1'b0;
         count_in = '0;
      end else if (!lock_ff) begin
         count_in = count_sum;
         if (count_sum > {1'b0, debounce_ticks}) begin
            count_in = '0;
            lock_in  = 1'b1;
            fire     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lock_ff  <= 1'b0;
         count_ff <= '0;
      end else if (enable) begin
         lock_ff  <= lock_in;
         count_ff <= count_in;
      end
   end

   a_fire_locks: assert property (@(posedge clock) disable iff (reset)
      enable && fire |=> lock_ff)
      else $error("simple key fired without taking the lock");

   a_no_fire_locked: assert property (@(posedge clock) disable iff (reset)
      lock_ff && !level |-> !fire)
      else $error("simple key fired while locked");

   a_count_clear: assert property (@(posedge clock) disable iff (reset)
      enable && level |=> count_ff == '0 && !lock_ff)
      else $error("simple key count not cleared on release");

endmodule

FILE: rtl/core/fkc_click_key.sv
module fkc_click_key (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  logic                     level,
   input  fkc_pkg::cfg_type         cfg,
   output fkc_pkg::click_event_type events
);
   import fkc_pkg::*;

   logic               lock_ff, lock_in;
   logic [CNT_W-1:0]   press_ff, press_in;
   logic [LONG_W-1:0]  repeat_ff, repeat_in;
   logic [LONG_W-1:0]  gap_ff, gap_in;
   logic [TALLY_W-1:0] tally_ff, tally_in;

   logic [CNT_W-1:0]   press_sum;
   logic [LONG_W-1:0]  repeat_sum;
   logic [LONG_W-1:0]  gap_sum;
   logic [TALLY_W-1:0] tally_sum;

   always_comb begin
      lock_in    = lock_ff;
      press_in   = press_ff;
      repeat_in  = repeat_ff;
      gap_in     = gap_ff;
      tally_in   = tally_ff;
      events     = '0;
      press_sum  = press_ff + CNT_W'(1);
      repeat_sum = repeat_ff + LONG_W'(1);
      gap_sum    = gap_ff + LONG_W'(1);
      tally_sum  = tally_ff + TALLY_W'(1);
      if (level) begin
         lock_in  = 1'b0;
         press_in = '0;
         // gap only runs while presses are pending
         if (tally_ff != '0) begin
            gap_in = gap_sum;
            if (gap_sum > cfg.double_gap_ticks) begin
               events.single_click = (tally_ff == TALLY_W'(1));
               gap_in   = '0;
               tally_in = '0;
            end
         end
      end else if (!lock_ff) begin
         press_in = press_sum;
         if (press_sum > {1'b0, cfg.debounce_ticks}) begin
            press_in = '0;
            gap_in   = '0;
            tally_in = tally_sum;
            lock_in  = 1'b1;
            events.double_click = (tally_sum == TALLY_W'(2));
         end
      end else if (press_ff < {1'b0, cfg.long_hold_ticks}) begin
         press_in = press_sum;
      end else begin
         // repeat count persists across releases
         repeat_in = repeat_sum;
         if (repeat_sum > cfg.repeat_ticks) begin
            repeat_in = '0;
            events.long_press = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lock_ff   <= 1'b0;
         press_ff  <= '0;
         repeat_ff <= '0;
         gap_ff    <= '0;
         tally_ff  <= '0;
      end else if (enable) begin
         lock_ff   <= lock_in;
         press_ff  <= press_in;
         repeat_ff <= repeat_in;
         gap_ff    <= gap_in;
         tally_ff  <= tally_in;
      end
   end

   a_one_event: assert property (@(posedge clock) disable iff (reset)
      $onehot0(events))
      else $error("click key raised more than one event");

   a_double_locks: assert property (@(posedge clock) disable iff (reset)
      enable && events.double_click |=> lock_ff && tally_ff == TALLY_W'(2))
      else $error("double click without lock and tally of two");

   a_single_clears: assert property (@(posedge clock) disable iff (reset)
      enable && events.single_click |=> tally_ff == '0 && gap_ff == '0)
      else $error("single click did not clear the gap state");

   a_long_needs_lock: assert property (@(posedge clock) disable iff (reset)
      events.long_press |-> lock_ff && !level)
      else $error("long press outside a locked hold");

endmodule

FILE: rtl/core/fkc_out_queue.sv
module fkc_out_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [fkc_pkg::CODE_W-1:0]  push_code,
   output logic                        full,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [fkc_pkg::CODE_W-1:0]  rsp_code
);
   import fkc_pkg::*;

   logic [CODE_W-1:0] slot_ff [2];
   logic [1:0]        count_ff, count_in;
   logic              head_ff, head_in;
   logic              tail;
   logic              pop;

   assign full      = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_code  = slot_ff[head_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign tail      = head_ff ^ count_ff[0];

   always_comb begin
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      head_in  = head_ff ^ pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         head_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         head_ff  <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[tail] <= push_code;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result queue count out of range");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into a full result queue");

   a_hold_count: assert property (@(posedge clock) disable iff (reset)
      !push && !pop |=> $stable(count_ff))
      else $error("result queue count moved without a transaction");

endmodule
